/* rtl/core/rvmie_pkg.sv */
// Package for the register VM instruction executor: opcodes, status codes, sizes.
// Depends on nothing; used by rvmie_div and register_vm_instruction_executor.
package rvmie_pkg;
	localparam int NUM_REGS = 16;
	localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_MOV = 4'd1;
	localparam logic [3:0] OP_ADD = 4'd2;
	localparam logic [3:0] OP_SUB = 4'd3;
	localparam logic [3:0] OP_MUL = 4'd4;
	localparam logic [3:0] OP_DIV = 4'd5;
	localparam logic [3:0] OP_EQ = 4'd6;
	localparam logic [3:0] OP_GT = 4'd7;
	localparam logic [3:0] OP_LT = 4'd8;
	localparam logic [3:0] OP_JMP = 4'd9;
	localparam logic [3:0] OP_JZ = 4'd10;
	localparam logic [3:0] OP_RET = 4'd11;
	localparam logic [3:0] OP_HALT = 4'd12;
	localparam logic [3:0] OP_NATIVE = 4'd13;

	localparam logic [7:0] NATIVE_KEY_ONE = 8'd1;
	localparam logic [7:0] NATIVE_KEY_TWO = 8'd2;
	localparam logic [7:0] NATIVE_SLEEP = 8'd3;

	localparam logic [2:0] ST_RUN = 3'd0;
	localparam logic [2:0] ST_HALT = 3'd1;
	localparam logic [2:0] ST_REG = 3'd2;
	localparam logic [2:0] ST_DIV0 = 3'd3;
	localparam logic [2:0] ST_PC = 3'd4;
	localparam logic [2:0] ST_OPC = 3'd5;
	localparam logic [2:0] ST_STEPS = 3'd6;

	localparam logic [1:0] ADDR_REG_COUNT = 2'd0;
	localparam logic [1:0] ADDR_PROG_LEN = 2'd1;
	localparam logic [1:0] ADDR_STEP_BUDGET = 2'd2;

	typedef struct packed {
		logic start;
		logic neg;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;
endpackage

/* rtl/core/rvmie_ram.sv */
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.
module rvmie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

/* rtl/core/rvmie_div.sv */
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// Depends on rvmie_pkg.
module rvmie_div (
	input logic clk,
	input logic arst_n,
	input rvmie_pkg::div_req_t req,
	output logic busy,
	output logic done,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0] cnt_q;
	logic neg_q, busy_q, done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

/* rtl/core/register_vm_instruction_executor.sv */
// Register VM executor: one request is one instruction, answered by one result.
// Most results are ready after a register file read, then execute and write back; div
// results also wait for the divider, which produces one quotient bit per cycle.
// A new request is taken only in the idle state, once the previous result has been accepted.
// Depends on rvmie_pkg, rvmie_ram, rvmie_div. Registers sit in a 16-entry RAM cleared by
// a sweep after reset and on each restart, during which no request is taken.
module register_vm_instruction_executor (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic restart,
	input logic [3:0] op,
	input logic [7:0] dst_reg,
	input logic [7:0] lhs_reg,
	input logic [7:0] rhs_reg,
	input logic [1:0] imm_mode,
	input logic [7:0] native_kind,
	input logic [15:0] jump_target,
	input logic signed [31:0] immediate,
	input logic key_one,
	input logic key_two,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] next_pc,
	output logic [2:0] status,
	output logic signed [31:0] return_value,
	output logic sleep_request,
	output logic [30:0] sleep_ms,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int AW = rvmie_pkg::REG_AW;
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic [2:0] state_q;
	logic [AW:0] clr_q;
	logic [4:0] nregs_q;
	logic [15:0] prog_len_q;
	logic [31:0] budget_q;
	logic [15:0] pc_q;
	logic [2:0] stop_q;
	logic [31:0] retv_q, steps_q;
	logic restart_pend_q;

	// Latched instruction
	logic [3:0] op_s1;
	logic [7:0] dst_s1, lhs_s1, rhs_s1, kind_s1;
	logic [1:0] mode_s1;
	logic [15:0] tgt_s1;
	logic [31:0] imm_s1;
	logic k1_s1, k2_s1;

	logic o_slp_q;
	logic [30:0] o_ms_q;

	logic in_acc, wr_acc;
	logic we;
	logic [AW-1:0] waddr;
	logic [31:0] wdata, rd_a, rd_b;
	logic [AW-1:0] ra, rb;
	logic [7:0] lhs, rhs;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign pready = 1'b1;
	assign wr_acc = psel && penable && pwrite;

	function automatic logic reg_ok(input logic [7:0] r, input logic [4:0] cnt);
		reg_ok = ({1'b0, r} < {4'd0, cnt}) && ({1'b0, r} < 9'(rvmie_pkg::NUM_REGS));
	endfunction

	assign lhs = in_acc ? lhs_reg : lhs_s1;
	assign rhs = in_acc ? rhs_reg : rhs_s1;
	assign ra = lhs[AW-1:0];
	assign rb = rhs[AW-1:0];

	rvmie_ram #(.WIDTH(32), .DEPTH(rvmie_pkg::NUM_REGS)) u_rf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .raddr_b(rb), .rdata_a(rd_a), .rdata_b(rd_b)
	);

	// Execute stage decode
	logic [31:0] a_v, b_v, res_v, sleep_v;
	logic dst_ok, lhs_ok, rhs_ok;
	logic [2:0] err;
	logic do_wr, take_jump, is_ret, is_halt, is_sleep, is_div;
	always_comb begin
		dst_ok = reg_ok(dst_s1, nregs_q);
		lhs_ok = reg_ok(lhs_s1, nregs_q);
		rhs_ok = reg_ok(rhs_s1, nregs_q);
		a_v = mode_s1[0] ? imm_s1 : rd_a;
		b_v = mode_s1[1] ? imm_s1 : rd_b;
		sleep_v = mode_s1[1] ? imm_s1 : rd_a;
		err = rvmie_pkg::ST_RUN;
		do_wr = 1'b0;
		take_jump = 1'b0;
		is_ret = 1'b0;
		is_halt = 1'b0;
		is_sleep = 1'b0;
		is_div = 1'b0;
		res_v = '0;
		case (op_s1)
			rvmie_pkg::OP_NOP: begin
			end
			rvmie_pkg::OP_MOV: begin
				res_v = b_v;
				if (!mode_s1[1]) res_v = rd_a;
				if (!dst_ok || (!mode_s1[1] && !lhs_ok)) err = rvmie_pkg::ST_REG;
				do_wr = 1'b1;
			end
			rvmie_pkg::OP_ADD, rvmie_pkg::OP_SUB, rvmie_pkg::OP_MUL,
			rvmie_pkg::OP_DIV, rvmie_pkg::OP_EQ, rvmie_pkg::OP_GT,
			rvmie_pkg::OP_LT: begin
				do_wr = 1'b1;
				if (!dst_ok || (!mode_s1[0] && !lhs_ok) || (!mode_s1[1] && !rhs_ok))
					err = rvmie_pkg::ST_REG;
				else if (op_s1 == rvmie_pkg::OP_DIV && b_v == 32'd0)
					err = rvmie_pkg::ST_DIV0;
				case (op_s1)
					rvmie_pkg::OP_ADD: res_v = a_v + b_v;
					rvmie_pkg::OP_SUB: res_v = a_v - b_v;
					rvmie_pkg::OP_MUL: res_v = a_v * b_v;
					rvmie_pkg::OP_EQ: res_v = {31'd0, a_v == b_v};
					rvmie_pkg::OP_GT: res_v = {31'd0, $signed(a_v) > $signed(b_v)};
					rvmie_pkg::OP_LT: res_v = {31'd0, $signed(a_v) < $signed(b_v)};
					default: res_v = '0;
				endcase
				is_div = (op_s1 == rvmie_pkg::OP_DIV);
			end
			rvmie_pkg::OP_JMP: take_jump = 1'b1;
			rvmie_pkg::OP_JZ: begin
				if (!lhs_ok) err = rvmie_pkg::ST_REG;
				take_jump = (rd_a == 32'd0);
			end
			rvmie_pkg::OP_RET: begin
				is_ret = 1'b1;
				res_v = mode_s1[0] ? imm_s1 : rd_a;
				if (!mode_s1[0] && !lhs_ok) err = rvmie_pkg::ST_REG;
			end
			rvmie_pkg::OP_HALT: is_halt = 1'b1;
			rvmie_pkg::OP_NATIVE: begin
				do_wr = 1'b1;
				if (!dst_ok) err = rvmie_pkg::ST_REG;
				else if (kind_s1 == rvmie_pkg::NATIVE_KEY_ONE) res_v = {31'd0, k1_s1};
				else if (kind_s1 == rvmie_pkg::NATIVE_KEY_TWO) res_v = {31'd0, k2_s1};
				else if (kind_s1 == rvmie_pkg::NATIVE_SLEEP) begin
					is_sleep = 1'b1;
					if (!mode_s1[1] && !lhs_ok) err = rvmie_pkg::ST_REG;
				end else err = rvmie_pkg::ST_OPC;
			end
			default: err = rvmie_pkg::ST_OPC;
		endcase
	end

	rvmie_pkg::div_req_t dreq;
	logic dbusy, ddone;
	logic [31:0] dquo;
	assign dreq.start = (state_q == S_EXEC) && is_div && (err == rvmie_pkg::ST_RUN)
		&& (pc_q < prog_len_q) && (stop_q == rvmie_pkg::ST_RUN);
	assign dreq.neg = a_v[31] ^ b_v[31];
	assign dreq.num = a_v[31] ? (32'd0 - a_v) : a_v;
	assign dreq.den = b_v[31] ? (32'd0 - b_v) : b_v;

	rvmie_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq),
		.busy(dbusy), .done(ddone), .quotient(dquo)
	);

	// Commit of a successful step.
	logic ok_exec;
	logic [31:0] steps_n;
	assign ok_exec = (state_q == S_EXEC) && (stop_q == rvmie_pkg::ST_RUN)
		&& (pc_q < prog_len_q) && (err == rvmie_pkg::ST_RUN) && !is_div;
	assign steps_n = (steps_q == 32'hFFFF_FFFF) ? steps_q : steps_q + 32'd1;

	always_comb begin
		we = 1'b0;
		waddr = dst_s1[AW-1:0];
		wdata = is_sleep ? 32'd0 : res_v;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = clr_q[AW-1:0];
			wdata = '0;
		end else if (ddone) begin
			we = 1'b1;
			wdata = dquo;
		end else if (ok_exec && do_wr) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			nregs_q <= 5'd16;
			prog_len_q <= 16'd1;
			budget_q <= '0;
			pc_q <= '0;
			stop_q <= rvmie_pkg::ST_RUN;
			retv_q <= '0;
			steps_q <= '0;
			o_slp_q <= 1'b0;
			o_ms_q <= '0;
		end else begin
			if (wr_acc) begin
				case (paddr[3:2])
					rvmie_pkg::ADDR_REG_COUNT: nregs_q <= pwdata[4:0];
					rvmie_pkg::ADDR_PROG_LEN: prog_len_q <= pwdata[15:0];
					rvmie_pkg::ADDR_STEP_BUDGET: budget_q <= pwdata;
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(rvmie_pkg::NUM_REGS - 1)) begin
						state_q <= restart_pend_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						if (restart) begin
							pc_q <= '0;
							stop_q <= rvmie_pkg::ST_RUN;
							retv_q <= '0;
							steps_q <= '0;
							o_slp_q <= 1'b0;
							o_ms_q <= '0;
							clr_q <= '0;
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					o_slp_q <= 1'b0;
					o_ms_q <= '0;
					if (stop_q != rvmie_pkg::ST_RUN) begin
					end else if (pc_q >= prog_len_q) begin
						stop_q <= rvmie_pkg::ST_PC;
					end else if (err != rvmie_pkg::ST_RUN) begin
						stop_q <= err;
					end else if (is_div) begin
						state_q <= S_DIV;
					end else begin
						pc_q <= take_jump ? tgt_s1 : pc_q + 16'd1;
						if (is_ret) retv_q <= res_v;
						if (is_sleep) begin
							o_slp_q <= 1'b1;
							o_ms_q <= sleep_v[31] ? 31'd0 : sleep_v[30:0];
						end
						steps_q <= steps_n;
						if (budget_q != 32'd0 && steps_n > budget_q)
							stop_q <= rvmie_pkg::ST_STEPS;
						else if (is_ret || is_halt)
							stop_q <= rvmie_pkg::ST_HALT;
					end
				end
				S_DIV: begin
					if (ddone) begin
						pc_q <= pc_q + 16'd1;
						steps_q <= steps_n;
						if (budget_q != 32'd0 && steps_n > budget_q)
							stop_q <= rvmie_pkg::ST_STEPS;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Restart produces a result once the clearing sweep ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_pend_q <= 1'b0;
		end else if (state_q == S_IDLE && in_acc) begin
			restart_pend_q <= restart;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1 <= op;
			dst_s1 <= dst_reg;
			lhs_s1 <= lhs_reg;
			rhs_s1 <= rhs_reg;
			mode_s1 <= imm_mode;
			kind_s1 <= native_kind;
			tgt_s1 <= jump_target;
			imm_s1 <= immediate;
			k1_s1 <= key_one;
			k2_s1 <= key_two;
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign next_pc = pc_q;
	assign status = stop_q;
	assign return_value = retv_q;
	assign sleep_request = o_slp_q;
	assign sleep_ms = o_ms_q;

	always_comb begin
		case (paddr[3:2])
			rvmie_pkg::ADDR_REG_COUNT: prdata = {27'd0, nregs_q};
			rvmie_pkg::ADDR_PROG_LEN: prdata = {16'd0, prog_len_q};
			rvmie_pkg::ADDR_STEP_BUDGET: prdata = budget_q;
			default: prdata = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dbusy |-> in_stall)
		else $error("request accepted during division");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		ddone |-> (state_q == S_DIV))
		else $error("divider finished outside division state");
	a_sleep_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sleep_request) |->
		(status == rvmie_pkg::ST_RUN || status == rvmie_pkg::ST_STEPS))
		else $error("sleep reported with a stop code");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(stop_q) != rvmie_pkg::ST_RUN && state_q != S_CLEAR
		&& $past(state_q) != S_IDLE) |-> $stable(stop_q))
		else $error("stop code changed while stopped");
`endif
endmodule
